// ===== sv/otcb_pkg.sv =====
// ----------------------------------------------------------------------------
// otcb_pkg
// shared types and constants of the overlay threshold color blend pipeline
// ----------------------------------------------------------------------------
package otcb_pkg;

    localparam int VAL_W   = 34;   // signed width of sample and threshold arithmetic
    localparam int THR_W   = 31;
    localparam int RAT_W   = 32;   // clamped ratio numerator and denominator
    localparam int C_W     = 17;
    localparam int E_W     = 18;
    localparam int PC_W    = C_W + RAT_W;
    localparam int PE_W    = 50;
    localparam int T_W     = 48;
    localparam int Q_W     = 8;
    localparam int LANE_ST = 6;    // register stages inside one color lane
    localparam int NUM_ST  = 8;    // register stages from input to output

    localparam int ADDR_W  = 5;

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        REG_MIN      = 3'd0,
        REG_MID      = 3'd1,
        REG_MAX      = 3'd2,
        REG_OPACITY  = 3'd3,
        REG_SCALE    = 3'd4,
        REG_METHOD   = 3'd5,
        REG_INVERSE  = 3'd6,
        REG_TRUNCATE = 3'd7
    } reg_idx_t;

    localparam logic [1:0] SCALE_GREEN_RED = 2'd0;
    localparam logic [1:0] SCALE_HEAT      = 2'd1;
    localparam logic [1:0] SCALE_BLUE_RED  = 2'd2;
    localparam logic       METHOD_LINEAR   = 1'b0;

    localparam byte_t FULL = 8'd255;

    typedef struct packed {
        logic [THR_W-1:0] min_thr;
        logic [THR_W-1:0] mid_thr;
        logic [THR_W-1:0] max_thr;
        logic [8:0]       op;       // saturated opacity
        logic [1:0]       scale;
        logic             method;
        logic             inverse;
        logic             trunc;
    } cfg_t;

    // first stage: raw ratio and the two colors of each lane
    typedef struct packed {
        logic [VAL_W-1:0] num;
        logic [VAL_W-1:0] den;
        byte_t [2:0]      a;
        byte_t [2:0]      b;
        byte_t [2:0]      bg;
        logic             last;
    } s1_t;

    // second stage: clamped ratio and blend coefficients of each lane
    typedef struct packed {
        logic [RAT_W-1:0]       n;
        logic [RAT_W-1:0]       d;
        logic [2:0][C_W-1:0]    c;
        logic [2:0][E_W-1:0]    e;
        logic                   last;
    } s2_t;

endpackage

// ===== sv/otcb_select.sv =====
// ----------------------------------------------------------------------------
// otcb_select
// side decision, color pair lookup and raw ratio selection, one stage
// ----------------------------------------------------------------------------
module otcb_select
    import otcb_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  cfg_t        cfg,
    input  logic [31:0] overlay_value,
    input  byte_t       bg_red,
    input  byte_t       bg_green,
    input  byte_t       bg_blue,
    input  logic        last_point,
    output s1_t         s1
);

    logic signed [VAL_W-1:0] v, mn, md, mx;
    logic                    pos, neg, swap;
    byte_t [2:0]             cmin, cmax, bg;
    s1_t                     s1_reg, s1_next;

    assign v  = VAL_W'($signed(overlay_value));
    assign mn = $signed({3'b000, cfg.min_thr});
    assign md = $signed({3'b000, cfg.mid_thr});
    assign mx = $signed({3'b000, cfg.max_thr});
    assign bg = {bg_blue, bg_green, bg_red};

    always_comb
    begin
        byte_t [2:0] lo, hi;
        pos  = (v >= mn) && !(cfg.inverse && cfg.trunc);
        neg  = !pos && (v <= -mn) && !(cfg.trunc && !cfg.inverse);
        swap = neg ^ cfg.inverse;
        unique case (cfg.scale)
            SCALE_GREEN_RED:
            begin
                lo = {8'd0, FULL, 8'd0};
                hi = {8'd0, 8'd0, FULL};
            end
            SCALE_BLUE_RED:
            begin
                lo = {FULL, 8'd0, 8'd0};
                hi = {8'd0, 8'd0, FULL};
            end
            default:
            begin
                lo = {8'd0, 8'd0, FULL};
                hi = {8'd0, FULL, FULL};
            end
        endcase
        // red and blue trade places
        cmin = swap ? {lo[0], lo[1], lo[2]} : lo;
        cmax = swap ? {hi[0], hi[1], hi[2]} : hi;
    end

    always_comb
    begin
        s1_next.last = last_point;
        s1_next.bg   = bg;
        priority if (!(pos || neg))
        begin
            s1_next.num = '0;
            s1_next.den = VAL_W'(1);
            s1_next.a   = bg;
            s1_next.b   = bg;
        end
        else if (cfg.method == METHOD_LINEAR)
        begin
            s1_next.num = pos ? mx - v : v + mx;
            s1_next.den = mx - md;
            s1_next.a   = cmin;
            s1_next.b   = cmax;
        end
        else if (pos ? (v < md) : (v >= -md))
        begin
            // fade in from the background
            s1_next.num = pos ? md - v : md + v;
            s1_next.den = md - mn;
            s1_next.a   = bg;
            s1_next.b   = cmin;
        end
        else if (pos ? (v <= mx) : (v >= -mx))
        begin
            s1_next.num = pos ? mx - v : mx + v;
            s1_next.den = mx - md;
            s1_next.a   = cmin;
            s1_next.b   = cmax;
        end
        else
        begin
            s1_next.num = '0;
            s1_next.den = VAL_W'(1);
            s1_next.a   = cmax;
            s1_next.b   = cmax;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

// ===== sv/otcb_ratio.sv =====
// ----------------------------------------------------------------------------
// otcb_ratio
// ratio normalize and clamp, per-lane blend coefficients, one stage
// ----------------------------------------------------------------------------
module otcb_ratio
    import otcb_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [8:0] op,
    input  s1_t        s1,
    output s2_t        s2
);

    logic signed [VAL_W-1:0] num, den, n1, d1, nc;
    logic                    dz, dn;
    s2_t                     s2_reg, s2_next;
    logic [8:0]              op_inv;

    assign num    = $signed(s1.num);
    assign den    = $signed(s1.den);
    assign op_inv = 9'd256 - op;

    always_comb
    begin
        dz = (den == '0);
        dn = den[VAL_W-1];
        n1 = dz ? '0 : (dn ? -num : num);
        d1 = dz ? VAL_W'(1) : (dn ? -den : den);
        if (n1 < 0)
        begin
            nc = '0;
        end
        else if (n1 > d1)
        begin
            nc = d1;
        end
        else
        begin
            nc = n1;
        end
    end

    always_comb
    begin
        logic signed [9:0]  diff;
        logic signed [19:0] prod;
        s2_next.n    = nc[RAT_W-1:0];
        s2_next.d    = d1[RAT_W-1:0];
        s2_next.last = s1.last;
        for (int k = 0; k < 3; k++)
        begin
            // bg*(256-op) + b*op and (a-b)*op
            s2_next.c[k] = {9'd0, s1.bg[k]} * {8'd0, op_inv}
                         + {9'd0, s1.b[k]} * {8'd0, op};
            diff = $signed({2'b00, s1.a[k]}) - $signed({2'b00, s1.b[k]});
            prod = diff * $signed({1'b0, op});
            s2_next.e[k] = prod[E_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

// ===== sv/otcb_lane.sv =====
// ----------------------------------------------------------------------------
// otcb_lane
// one color channel: products, sum and a two-bit-per-stage quotient
// ----------------------------------------------------------------------------
module otcb_lane
    import otcb_pkg::*;
(
    input  logic               clk,
    input  logic [LANE_ST-1:0] en,
    input  logic [RAT_W-1:0]   n,
    input  logic [RAT_W-1:0]   d,
    input  logic [C_W-1:0]     c,
    input  logic [E_W-1:0]     e,
    output byte_t              q
);

    logic [PC_W-1:0]        pc_reg;
    logic signed [PE_W-1:0] pe_reg;
    logic [RAT_W-1:0]       d3_reg, d4_reg;
    logic [T_W-1:0]         t_reg;
    logic signed [50:0]     tsum;
    logic signed [50:0]     pe_full;

    logic [T_W-1:0]   rem_reg [3];
    logic [RAT_W-1:0] dd_reg  [3];
    byte_t            q_reg   [4];

    assign pe_full = $signed(e) * $signed({1'b0, n});
    assign tsum    = $signed({2'b00, pc_reg}) + 51'(pe_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pc_reg <= {{RAT_W{1'b0}}, c} * {{C_W{1'b0}}, d};
            pe_reg <= pe_full[PE_W-1:0];
            d3_reg <= d;
        end
        if (en[1])
        begin
            t_reg  <= tsum[T_W-1:0];
            d4_reg <= d3_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_div
            logic [T_W-1:0]   rem_in, r1, r2, dh1, dh2;
            logic [RAT_W-1:0] dv;
            byte_t            q_in, q_next;

            if (g == 0)
            begin : g_first
                assign rem_in = t_reg;
                assign dv     = d4_reg;
                assign q_in   = '0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[g-1];
                assign dv     = dd_reg[g-1];
                assign q_in   = q_reg[g-1];
            end

            // compare against d*256 shifted to the current quotient bit
            assign dh1 = T_W'(dv) << (15 - 2 * g);
            assign dh2 = T_W'(dv) << (14 - 2 * g);

            always_comb
            begin
                q_next = q_in;
                if (rem_in >= dh1)
                begin
                    r1 = rem_in - dh1;
                    q_next[7 - 2 * g] = 1'b1;
                end
                else
                begin
                    r1 = rem_in;
                end
                if (r1 >= dh2)
                begin
                    r2 = r1 - dh2;
                    q_next[6 - 2 * g] = 1'b1;
                end
                else
                begin
                    r2 = r1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[2 + g])
                begin
                    q_reg[g] <= q_next;
                end
            end

            if (g < 3)
            begin : g_keep
                always_ff @(posedge clk)
                begin
                    if (en[2 + g])
                    begin
                        rem_reg[g] <= r2;
                        dd_reg[g]  <= dv;
                    end
                end
            end
        end
    endgenerate

    assign q = q_reg[3];

endmodule

// ===== sv/overlay_threshold_color_blend.sv =====
// ----------------------------------------------------------------------------
// overlay_threshold_color_blend
// threshold color mapping of a signed overlay sample blended over a background
// ----------------------------------------------------------------------------
// throughput: one item per cycle while out_stall is low; eight register
//   stages, the quotient is resolved two bits per stage in each color
//   lane
// reset: all stages empty, registers take min/mid/max 0, opacity 256,
//   heat scale, linear opaque mode, inverse and truncate off
// ----------------------------------------------------------------------------
module overlay_threshold_color_blend
    import otcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       overlay_value,
    input  byte_t             bg_red,
    input  byte_t             bg_green,
    input  byte_t             bg_blue,
    input  logic              last_point,

    output logic              out_valid,
    input  logic              out_stall,
    output byte_t             out_red,
    output byte_t             out_green,
    output byte_t             out_blue,
    output logic              last_out
);

    logic [THR_W-1:0]  min_reg, mid_reg, max_reg;
    logic [8:0]        opacity_reg;
    logic [1:0]        scale_reg;
    logic              method_reg, inverse_reg, trunc_reg;
    cfg_t              cfg;
    reg_idx_t          widx, ridx;

    logic [NUM_ST-1:0] vld_reg;
    logic [NUM_ST-1:0] en;
    logic [LANE_ST-1:0] last_reg;
    s1_t               s1;
    s2_t               s2;
    byte_t [2:0]       q;

    // configuration port
    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[4:2]);
    assign ridx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= '0;
            mid_reg     <= '0;
            max_reg     <= '0;
            opacity_reg <= 9'd256;
            scale_reg   <= SCALE_HEAT;
            method_reg  <= METHOD_LINEAR;
            inverse_reg <= 1'b0;
            trunc_reg   <= 1'b0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (widx)
                REG_MIN:      min_reg     <= pwdata[THR_W-1:0];
                REG_MID:      mid_reg     <= pwdata[THR_W-1:0];
                REG_MAX:      max_reg     <= pwdata[THR_W-1:0];
                REG_OPACITY:  opacity_reg <= pwdata[8:0];
                REG_SCALE:    scale_reg   <= pwdata[1:0];
                REG_METHOD:   method_reg  <= pwdata[0];
                REG_INVERSE:  inverse_reg <= pwdata[0];
                REG_TRUNCATE: trunc_reg   <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            REG_MIN:      prdata = {1'b0, min_reg};
            REG_MID:      prdata = {1'b0, mid_reg};
            REG_MAX:      prdata = {1'b0, max_reg};
            REG_OPACITY:  prdata = {23'd0, opacity_reg};
            REG_SCALE:    prdata = {30'd0, scale_reg};
            REG_METHOD:   prdata = {31'd0, method_reg};
            REG_INVERSE:  prdata = {31'd0, inverse_reg};
            REG_TRUNCATE: prdata = {31'd0, trunc_reg};
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.min_thr = min_reg;
        cfg.mid_thr = mid_reg;
        cfg.max_thr = max_reg;
        cfg.op      = (opacity_reg > 9'd256) ? 9'd256 : opacity_reg;
        cfg.scale   = scale_reg;
        cfg.method  = method_reg;
        cfg.inverse = inverse_reg;
        cfg.trunc   = trunc_reg;
    end

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en[NUM_ST-1] = !vld_reg[NUM_ST-1] || !out_stall;
        for (int k = NUM_ST - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NUM_ST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // batch mark rides alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            last_reg[0] <= s2.last;
        end
        for (int k = 1; k < LANE_ST; k++)
        begin
            if (en[k+2])
            begin
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    otcb_select u_select (
        .clk           (clk),
        .en            (en[0]),
        .cfg           (cfg),
        .overlay_value (overlay_value),
        .bg_red        (bg_red),
        .bg_green      (bg_green),
        .bg_blue       (bg_blue),
        .last_point    (last_point),
        .s1            (s1)
    );

    otcb_ratio u_ratio (
        .clk (clk),
        .en  (en[1]),
        .op  (cfg.op),
        .s1  (s1),
        .s2  (s2)
    );

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            otcb_lane u_lane (
                .clk (clk),
                .en  (en[NUM_ST-1:2]),
                .n   (s2.n),
                .d   (s2.d),
                .c   (s2.c[g]),
                .e   (s2.e[g]),
                .q   (q[g])
            );
        end
    endgenerate

    assign out_valid = vld_reg[NUM_ST-1];
    assign out_red   = q[0];
    assign out_green = q[1];
    assign out_blue  = q[2];
    assign last_out  = last_reg[LANE_ST-1];

endmodule
